[src/segmented_lpf_sieve_window_test_defines.svh]
// Assertion helpers for the sieve window block checker.
`ifndef SEGMENTED_LPF_SIEVE_WINDOW_TEST_DEFINES_SVH
`define SEGMENTED_LPF_SIEVE_WINDOW_TEST_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define SLW_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off during reset.
`define SLW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/slw_pkg.sv]
// ----------------------------------------------------------------------------
// slw_pkg
// Shared types and constants for the segmented least-prime-factor sieve.
// ----------------------------------------------------------------------------
package slw_pkg;

    localparam int SEGMENT_SIZE_DEF = 65536;
    localparam int WINDOW_PAD_DEF   = 4096;

    localparam int BASE_W  = 48;
    localparam int LEN_W   = 17;
    localparam int PRIME_W = 24;
    localparam int OFF_W   = 16;
    localparam int CNT_W   = 32;
    localparam int K_W     = 13;

    localparam logic [LEN_W-1:0]  LEN_RESET = 17'd65536;
    localparam logic [K_W-1:0]    FIRST_K   = 13'd3;
    localparam logic [BASE_W-1:0] MIN_PRIME = 48'd5;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_SIEVE = 2'd1,
        MODE_TEST  = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic {
        CFG_SEG_BASE = 1'b0,
        CFG_SEG_LEN  = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_DIV,
        ST_SV_INIT,
        ST_SV_RD,
        ST_SV_WR,
        ST_T_INIT,
        ST_T_EVAL,
        ST_K_SQ,
        ST_K_QUAD,
        ST_K_CHK,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic clr_reset;
        logic div_step;
        logic sv_init;
        logic sv_rd;
        logic sv_wr;
        logic t_init;
        logic t_eval;
        logic k_sq;
        logic k_quad;
        logic k_chk;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  q_small;
        logic  clr_last;
        logic  div_last;
        logic  sv_go;
        logic  t_prime;
        logic  k_cont;
        logic  k_hit;
    } stat_t;

endpackage

[src/slw_ram.sv]
// ----------------------------------------------------------------------------
// slw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/slw_ctrl.sv]
// ----------------------------------------------------------------------------
// slw_ctrl
// Sequencer: steps clear, sieve and test items through the datapath.
// ----------------------------------------------------------------------------
module slw_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  slw_pkg::stat_t stat,
    output slw_pkg::cmd_t  cmd
);

    slw_pkg::state_t state_reg, state_next;
    logic            pend_reg, pend_next;
    logic            m_valid_reg, m_valid_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= slw_pkg::ST_CLEAR;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            slw_pkg::ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last) begin
                    state_next = pend_reg ? slw_pkg::ST_OUT : slw_pkg::ST_IDLE;
                end
            end
            slw_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    pend_next  = 1'b1;
                    state_next = slw_pkg::ST_DISPATCH;
                end
            end
            slw_pkg::ST_DISPATCH: begin
                case (stat.mode)
                    slw_pkg::MODE_CLEAR: begin
                        cmd.clr_reset = 1'b1;
                        state_next    = slw_pkg::ST_CLEAR;
                    end
                    slw_pkg::MODE_SIEVE: begin
                        state_next = stat.q_small ? slw_pkg::ST_OUT : slw_pkg::ST_DIV;
                    end
                    slw_pkg::MODE_TEST: state_next = slw_pkg::ST_T_INIT;
                    default:            state_next = slw_pkg::ST_OUT;
                endcase
            end
            slw_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = slw_pkg::ST_SV_INIT;
                end
            end
            slw_pkg::ST_SV_INIT: begin
                cmd.sv_init = 1'b1;
                state_next  = slw_pkg::ST_SV_RD;
            end
            slw_pkg::ST_SV_RD: begin
                if (stat.sv_go) begin
                    cmd.sv_rd  = 1'b1;
                    state_next = slw_pkg::ST_SV_WR;
                end else begin
                    state_next = slw_pkg::ST_OUT;
                end
            end
            slw_pkg::ST_SV_WR: begin
                cmd.sv_wr  = 1'b1;
                state_next = slw_pkg::ST_SV_RD;
            end
            slw_pkg::ST_T_INIT: begin
                cmd.t_init = 1'b1;
                state_next = slw_pkg::ST_T_EVAL;
            end
            slw_pkg::ST_T_EVAL: begin
                cmd.t_eval = 1'b1;
                state_next = stat.t_prime ? slw_pkg::ST_K_SQ : slw_pkg::ST_OUT;
            end
            slw_pkg::ST_K_SQ: begin
                cmd.k_sq   = 1'b1;
                state_next = slw_pkg::ST_K_QUAD;
            end
            slw_pkg::ST_K_QUAD: begin
                cmd.k_quad = 1'b1;
                state_next = slw_pkg::ST_K_CHK;
            end
            slw_pkg::ST_K_CHK: begin
                cmd.k_chk = 1'b1;
                if (!stat.k_cont || stat.k_hit) begin
                    state_next = slw_pkg::ST_OUT;
                end else begin
                    state_next = slw_pkg::ST_K_SQ;
                end
            end
            slw_pkg::ST_OUT: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    pend_next    = 1'b0;
                    state_next   = slw_pkg::ST_IDLE;
                end
            end
            default: state_next = slw_pkg::ST_IDLE;
        endcase
    end

    // result beat valid
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[src/slw_dp.sv]
// ----------------------------------------------------------------------------
// slw_dp
// Datapath: factor store, remainder unit, sieve walker and window test.
// ----------------------------------------------------------------------------
module slw_dp #(
    parameter int SEGMENT_SIZE = slw_pkg::SEGMENT_SIZE_DEF,
    parameter int WINDOW_PAD   = slw_pkg::WINDOW_PAD_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [slw_pkg::BASE_W-1:0]    cfg_wdata,
    input  logic [1:0]                    s_mode,
    input  logic [slw_pkg::PRIME_W-1:0]   s_sieve_prime,
    input  logic [slw_pkg::OFF_W-1:0]     s_offset,
    output logic                          m_status,
    output logic                          m_is_prime,
    output logic                          m_is_bad,
    output logic [slw_pkg::BASE_W-1:0]    m_candidate,
    output logic [slw_pkg::CNT_W-1:0]     m_prime_count,
    output logic [slw_pkg::CNT_W-1:0]     m_bad_count,
    input  slw_pkg::cmd_t                 cmd,
    output slw_pkg::stat_t                stat
);

    localparam int DEPTH  = SEGMENT_SIZE + WINDOW_PAD;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = ((IDX_W > slw_pkg::PRIME_W) ? IDX_W : slw_pkg::PRIME_W) + 1;
    localparam int CW     = (IDX_W > 18) ? IDX_W : 18;
    localparam int BW     = slw_pkg::BASE_W;
    localparam int PW     = slw_pkg::PRIME_W;
    localparam int KW     = slw_pkg::K_W;

    // configuration
    logic [BW-1:0]              base_reg;
    logic [slw_pkg::LEN_W-1:0]  len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            len_reg  <= slw_pkg::LEN_RESET;
        end else if (cfg_wr_en) begin
            case (slw_pkg::cfg_idx_t'(cfg_index))
                slw_pkg::CFG_SEG_BASE: base_reg <= cfg_wdata;
                slw_pkg::CFG_SEG_LEN:  len_reg  <= cfg_wdata[slw_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective length and window
    logic [slw_pkg::LEN_W-1:0] used_len;
    logic [IDX_W-1:0]          win_len;

    always_comb begin
        if (len_reg == '0) begin
            used_len = slw_pkg::LEN_W'(1);
        end else if (32'(len_reg) > 32'(SEGMENT_SIZE)) begin
            used_len = slw_pkg::LEN_W'(SEGMENT_SIZE);
        end else begin
            used_len = len_reg;
        end
        win_len = IDX_W'(used_len) + IDX_W'(WINDOW_PAD);
    end

    // item registers
    slw_pkg::mode_t mode_reg;
    logic [PW-1:0]  q_reg;
    logic [slw_pkg::OFF_W-1:0] off_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= slw_pkg::mode_t'(s_mode);
            q_reg    <= s_sieve_prime;
            off_reg  <= s_offset;
        end
    end

    // store
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [PW-1:0]     ram_wdata, ram_rdata;

    slw_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // clearing sweep
    logic [ADDR_W-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr_reset) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_wr) begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    // remainder of base by q, one bit a cycle
    logic [PW:0]   rem_reg;
    logic [5:0]    div_bit_reg;
    logic [PW:0]   rem_shift;
    logic [BW-1:0] qq_reg;

    assign rem_shift = {rem_reg[PW-1:0], base_reg[div_bit_reg]};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rem_reg     <= '0;
            div_bit_reg <= 6'(BW - 1);
        end else if (cmd.div_step) begin
            rem_reg     <= (rem_shift >= {1'b0, q_reg}) ? rem_shift - {1'b0, q_reg} : rem_shift;
            div_bit_reg <= div_bit_reg - 6'd1;
            qq_reg      <= q_reg * q_reg;
        end
    end

    // sieve walker
    logic [BW:0]      st_mult, start_abs, start_off;
    logic [PW:0]      to_next;
    logic [IDX_W-1:0] idx_reg;
    logic             sv_go_reg;
    logic [SUM_W-1:0] idx_sum;

    always_comb begin
        to_next   = (rem_reg == '0) ? '0 : ({1'b0, q_reg} - rem_reg);
        st_mult   = (BW+1)'(base_reg) + (BW+1)'(to_next);
        start_abs = (st_mult > {1'b0, qq_reg}) ? st_mult : {1'b0, qq_reg};
        start_off = start_abs - {1'b0, base_reg};
        idx_sum   = SUM_W'(idx_reg) + SUM_W'(q_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.sv_init) begin
            idx_reg   <= IDX_W'(start_off);
            sv_go_reg <= start_off < (BW+1)'(win_len);
        end else if (cmd.sv_wr) begin
            idx_reg   <= IDX_W'(idx_sum);
            sv_go_reg <= idx_sum < SUM_W'(win_len);
        end
    end

    // window test
    logic          oob_reg, prime_reg, bad_reg, inwin_reg;
    logic [BW-1:0] p_reg;
    logic [KW-1:0] k_reg;
    logic [2*KW-1:0] ksq_reg;
    logic [4*KW-1:0] k4_reg;
    logic [PW-1:0] f_reg;
    logic [CW-1:0] kidx;
    logic [4*KW:0] k_limit;
    logic          t_prime, k_cont, k_hit;

    always_comb begin
        kidx    = CW'(off_reg) + CW'(k_reg) - CW'(1);
        t_prime = !oob_reg && (p_reg >= slw_pkg::MIN_PRIME) && (ram_rdata == '0);
        k_limit = (4*KW+1)'(p_reg) + (4*KW+1)'(k_reg) - (4*KW+1)'(1);
        k_cont  = (4*KW+1)'(k4_reg) < k_limit;
        k_hit   = inwin_reg && (f_reg != '0) && ((2*KW)'(f_reg) > ksq_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            oob_reg   <= 1'b0;
            prime_reg <= 1'b0;
            bad_reg   <= 1'b0;
        end else if (cmd.t_init) begin
            oob_reg <= {1'b0, off_reg} >= used_len;
            p_reg   <= base_reg + BW'(off_reg);
        end else if (cmd.t_eval) begin
            prime_reg <= t_prime;
            bad_reg   <= 1'b1;
            k_reg     <= slw_pkg::FIRST_K;
        end else if (cmd.k_sq) begin
            ksq_reg   <= (2*KW)'(k_reg) * (2*KW)'(k_reg);
            inwin_reg <= kidx < CW'(win_len);
        end else if (cmd.k_quad) begin
            k4_reg <= (4*KW)'(ksq_reg) * (4*KW)'(ksq_reg);
            f_reg  <= ram_rdata;
        end else if (cmd.k_chk) begin
            if (k_cont && k_hit) begin
                bad_reg <= 1'b0;
            end
            k_reg <= k_reg + KW'(2);
        end
    end

    // store port muxing
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = clr_addr_reg;
        ram_wdata = '0;
        ram_re    = cmd.sv_rd || cmd.t_init || cmd.k_sq;
        ram_raddr = ADDR_W'(idx_reg);
        if (cmd.clr_wr) begin
            ram_we = 1'b1;
        end else if (cmd.sv_wr) begin
            ram_we    = (ram_rdata == '0);
            ram_waddr = ADDR_W'(idx_reg);
            ram_wdata = q_reg;
        end
        if (cmd.t_init) begin
            ram_raddr = ADDR_W'(off_reg);
        end else if (cmd.k_sq) begin
            ram_raddr = ADDR_W'(kidx);
        end
    end

    // running counts
    logic [slw_pkg::CNT_W-1:0] primes_reg, bads_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primes_reg <= '0;
            bads_reg   <= '0;
        end else if (cmd.out_load && prime_reg) begin
            if (primes_reg != '1) begin
                primes_reg <= primes_reg + slw_pkg::CNT_W'(1);
            end
            if (bad_reg && bads_reg != '1) begin
                bads_reg <= bads_reg + slw_pkg::CNT_W'(1);
            end
        end
    end

    // result register
    logic          res_status_reg, res_prime_reg, res_bad_reg;
    logic [BW-1:0] res_cand_reg;
    logic [slw_pkg::CNT_W-1:0] res_pc_reg, res_bc_reg;
    logic          is_test;

    assign is_test = (mode_reg == slw_pkg::MODE_TEST);

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            res_status_reg <= is_test && oob_reg;
            res_prime_reg  <= prime_reg;
            res_bad_reg    <= prime_reg && bad_reg;
            res_cand_reg   <= (is_test && !oob_reg) ? p_reg : '0;
            res_pc_reg     <= (prime_reg && primes_reg != '1) ?
                              primes_reg + slw_pkg::CNT_W'(1) : primes_reg;
            res_bc_reg     <= (prime_reg && bad_reg && bads_reg != '1) ?
                              bads_reg + slw_pkg::CNT_W'(1) : bads_reg;
        end
    end

    assign m_status      = res_status_reg;
    assign m_is_prime    = res_prime_reg;
    assign m_is_bad      = res_bad_reg;
    assign m_candidate   = res_cand_reg;
    assign m_prime_count = res_pc_reg;
    assign m_bad_count   = res_bc_reg;

    // status to the sequencer
    always_comb begin
        stat.mode     = mode_reg;
        stat.q_small  = q_reg < PW'(2);
        stat.clr_last = clr_addr_reg == ADDR_W'(DEPTH - 1);
        stat.div_last = div_bit_reg == '0;
        stat.sv_go    = sv_go_reg;
        stat.t_prime  = t_prime;
        stat.k_cont   = k_cont;
        stat.k_hit    = k_hit;
    end

endmodule

[src/segmented_lpf_sieve_window_test.sv]
// Clear and reset sweep the whole store, SEGMENT_SIZE+WINDOW_PAD entries (69632 by default).
// Sieve: a bit-serial remainder of the base by the prime, then for each multiple in
// the window one store read and one store write. Test: init and eval, then square, quad and check per odd k.
// One item at a time; a result waits in the output register while the next is taken.
// Reset: synchronous, active low; after reset the whole store is swept to zero,
// during which no beat is accepted.
// ----------------------------------------------------------------------------
// segmented_lpf_sieve_window_test
// Least-prime-factor segment sieve with a bad-prime window test.
// ----------------------------------------------------------------------------
module segmented_lpf_sieve_window_test #(
    parameter int SEGMENT_SIZE = slw_pkg::SEGMENT_SIZE_DEF,
    parameter int WINDOW_PAD   = slw_pkg::WINDOW_PAD_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [slw_pkg::BASE_W-1:0]  cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_mode,
    input  logic [slw_pkg::PRIME_W-1:0] s_sieve_prime,
    input  logic [slw_pkg::OFF_W-1:0]   s_offset,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_status,
    output logic                        m_is_prime,
    output logic                        m_is_bad,
    output logic [slw_pkg::BASE_W-1:0]  m_candidate,
    output logic [slw_pkg::CNT_W-1:0]   m_prime_count,
    output logic [slw_pkg::CNT_W-1:0]   m_bad_count
);

    slw_pkg::cmd_t  cmd;
    slw_pkg::stat_t stat;

    slw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    slw_dp #(
        .SEGMENT_SIZE (SEGMENT_SIZE),
        .WINDOW_PAD   (WINDOW_PAD)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_mode        (s_mode),
        .s_sieve_prime (s_sieve_prime),
        .s_offset      (s_offset),
        .m_status      (m_status),
        .m_is_prime    (m_is_prime),
        .m_is_bad      (m_is_bad),
        .m_candidate   (m_candidate),
        .m_prime_count (m_prime_count),
        .m_bad_count   (m_bad_count),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

[src/slw_checker.sv]
// ----------------------------------------------------------------------------
// slw_checker
// Port-level checks for the sieve window block, bound to the top level.
// ----------------------------------------------------------------------------
`include "segmented_lpf_sieve_window_test_defines.svh"

module slw_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_status,
    input logic                       m_is_prime,
    input logic                       m_is_bad,
    input logic [slw_pkg::BASE_W-1:0] m_candidate
);

    // a stalled result beat holds
`SLW_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_candidate), "result beat dropped or changed while stalled")

    // out-of-range offset carries no test outcome
`SLW_ASSERT_NOW(a_oob, aclk, aresetn, m_valid && m_status, !m_is_prime && !m_is_bad && m_candidate == '0, "out-of-range beat carries a test outcome")

    // only a prime can be bad
`SLW_ASSERT_NOW(a_bad, aclk, aresetn, m_valid && m_is_bad, m_is_prime, "bad flag without prime flag")

    // one item in flight
`SLW_ASSERT_NEXT(a_one, aclk, aresetn, s_valid && s_ready, !s_ready, "input taken while an item is in progress")

endmodule

bind segmented_lpf_sieve_window_test slw_checker u_chk (.*);

[tb/tb_segmented_lpf_sieve_window_test.sv]
// ----------------------------------------------------------------------------
// tb_segmented_lpf_sieve_window_test
// Self-checking bench for the segmented least-prime-factor sieve. A scoreboard
// keeps its own factor store and running counts and predicts each result beat
// as input beats are accepted. Stimulus: a directed opening, then phases at
// several segment settings, each an optional clear, an ascending run of base-prime sieves
// and a batch of candidate tests, with noise beats mixed in.
// ----------------------------------------------------------------------------
module tb_segmented_lpf_sieve_window_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BW          = slw_pkg::BASE_W;
    localparam int LW          = slw_pkg::LEN_W;
    localparam int PW          = slw_pkg::PRIME_W;
    localparam int OW          = slw_pkg::OFF_W;
    localparam int NW          = slw_pkg::CNT_W;
    localparam int WPAD        = slw_pkg::WINDOW_PAD_DEF;
    localparam int SEG_SIZE    = slw_pkg::SEGMENT_SIZE_DEF;
    localparam int STORE_DEPTH = SEG_SIZE + WPAD;
    localparam int IDLE_LIMIT  = 500000;

    typedef struct {
        bit          status;
        bit          is_prime;
        bit          is_bad;
        bit [BW-1:0] candidate;
        bit [NW-1:0] prime_count;
        bit [NW-1:0] bad_count;
    } lpf_result_t;

    // Scoreboard: own copy of the factor store, counters and registers
    class lpf_scoreboard;
        bit [PW-1:0]  factor_mem [STORE_DEPTH];
        bit [NW-1:0]  primes_seen;
        bit [NW-1:0]  bad_seen;
        bit [BW-1:0]  seg_base;
        bit [LW-1:0]  seg_len;
        lpf_result_t  pending_q [$];
        int           errors;
        int           n_checked;
        int           n_prime;
        int           n_bad;

        function new();
            primes_seen = 0;
            bad_seen    = 0;
            seg_base    = 0;
            seg_len     = slw_pkg::LEN_RESET;
            errors      = 0;
            n_checked   = 0;
            n_prime     = 0;
            n_bad       = 0;
            wipe_store();
        endfunction

        function void wipe_store();
            foreach (factor_mem[i]) factor_mem[i] = 0;
        endfunction

        function void set_reg(slw_pkg::cfg_idx_t idx, bit [BW-1:0] val);
            if (idx == slw_pkg::CFG_SEG_BASE) seg_base = val;
            else seg_len = val[LW-1:0];
        endfunction

        function longint unsigned eff_len();
            longint unsigned n;
            n = seg_len;
            if (n == 0) n = 1;
            if (n > SEG_SIZE) n = SEG_SIZE;
            return n;
        endfunction

        // Reads past the covered window see an unmarked entry
        function bit [PW-1:0] factor_at(longint unsigned idx);
            if (idx >= eff_len() + WPAD || idx >= STORE_DEPTH) return 0;
            return factor_mem[idx];
        endfunction

        function void mark_multiples(longint unsigned q);
            longint unsigned first, lim, m;
            if (q < 2) return;
            first = (seg_base + q - 1) / q * q;
            if (first < q * q) first = q * q;
            lim = seg_base + eff_len() + WPAD;
            for (m = first; m < lim; m += q) begin
                if (m - seg_base < STORE_DEPTH && factor_mem[m - seg_base] == 0)
                    factor_mem[m - seg_base] = q[PW-1:0];
            end
        endfunction

        function void note_item(slw_pkg::mode_t md, bit [PW-1:0] q, bit [OW-1:0] off);
            lpf_result_t r;
            longint unsigned p, k;
            r = '{default: 0};
            case (md)
                slw_pkg::MODE_CLEAR: wipe_store();
                slw_pkg::MODE_SIEVE: mark_multiples(q);
                slw_pkg::MODE_TEST: begin
                    if (off >= eff_len()) begin
                        r.status = 1;
                    end else begin
                        p = (seg_base + off) & 48'hFFFF_FFFF_FFFF;
                        r.candidate = p[BW-1:0];
                        if (p >= 5 && factor_at(off) == 0) begin
                            r.is_prime = 1;
                            r.is_bad   = 1;
                            if (primes_seen != 32'hFFFF_FFFF) primes_seen++;
                            // bad unless a wide-enough factor sits near the prime
                            for (k = 3; k * k * k * k < p - 1 + k; k += 2) begin
                                if (factor_at(off + k - 1) != 0 &&
                                    factor_at(off + k - 1) > k * k) begin
                                    r.is_bad = 0;
                                    break;
                                end
                            end
                            if (r.is_bad && bad_seen != 32'hFFFF_FFFF) bad_seen++;
                        end
                    end
                end
                default: ;
            endcase
            r.prime_count = primes_seen;
            r.bad_count   = bad_seen;
            pending_q.push_back(r);
        endfunction

        task flag(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(lpf_result_t got);
            lpf_result_t want;
            if (pending_q.size() == 0) begin
                flag("result beat with nothing outstanding");
                return;
            end
            want = pending_q.pop_front();
            n_checked++;
            if (got.is_prime) n_prime++;
            if (got.is_bad) n_bad++;
            if (got.status != want.status)
                flag($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.is_prime != want.is_prime)
                flag($sformatf("is_prime got %0d want %0d (cand %0d)",
                               got.is_prime, want.is_prime, want.candidate));
            if (got.is_bad != want.is_bad)
                flag($sformatf("is_bad got %0d want %0d (cand %0d)",
                               got.is_bad, want.is_bad, want.candidate));
            if (got.candidate != want.candidate)
                flag($sformatf("candidate got %0d want %0d", got.candidate, want.candidate));
            if (got.prime_count != want.prime_count)
                flag($sformatf("prime_count got %0d want %0d",
                               got.prime_count, want.prime_count));
            if (got.bad_count != want.bad_count)
                flag($sformatf("bad_count got %0d want %0d", got.bad_count, want.bad_count));
        endtask
    endclass

    logic            aclk;
    logic            aresetn;
    logic            cfg_wr_en;
    logic            cfg_index;
    logic [BW-1:0]   cfg_wdata;
    logic            s_valid;
    logic            s_ready;
    logic [1:0]      s_mode;
    logic [PW-1:0]   s_sieve_prime;
    logic [OW-1:0]   s_offset;
    logic            m_valid;
    logic            m_ready;
    logic            m_status;
    logic            m_is_prime;
    logic            m_is_bad;
    logic [BW-1:0]   m_candidate;
    logic [NW-1:0]   m_prime_count;
    logic [NW-1:0]   m_bad_count;

    lpf_scoreboard sb = new();
    bit            calm;
    int            idle_cycles;
    int            items_sent;
    int            settings_used;
    int unsigned   small_primes [5]  = '{2, 3, 5, 7, 11};
    int unsigned   probe_offs   [13] = '{0, 1, 2, 3, 4, 5, 9, 25, 49, 97, 99, 100, 65535};

    segmented_lpf_sieve_window_test u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_sieve_prime (s_sieve_prime),
        .s_offset      (s_offset),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_is_prime    (m_is_prime),
        .m_is_bad      (m_is_bad),
        .m_candidate   (m_candidate),
        .m_prime_count (m_prime_count),
        .m_bad_count   (m_bad_count)
    );

    initial aclk = 0;
    always #2 aclk = ~aclk;

    // Result side: random back-pressure, set on the falling edge
    always @(negedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 35);
    end

    // Result checking and stall watchdog
    always @(posedge aclk) begin
        lpf_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.status      = m_status;
            got.is_prime    = m_is_prime;
            got.is_bad      = m_is_bad;
            got.candidate   = m_candidate;
            got.prime_count = m_prime_count;
            got.bad_count   = m_bad_count;
            sb.check_result(got);
        end
        if ((m_valid && m_ready) || (s_valid && s_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Register write; called at a falling edge while the block is idle
    task automatic write_reg(slw_pkg::cfg_idx_t idx, bit [BW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // One input beat; entered and left at a falling edge
    task automatic push_item(slw_pkg::mode_t md, bit [PW-1:0] q, bit [OW-1:0] off);
        if (!calm && $urandom_range(0, 99) < 35) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= md;
        s_sieve_prime <= q;
        s_offset      <= off;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(md, q, off);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    function automatic bit is_prime_int(int n);
        if (n < 2) return 0;
        for (int d = 2; d * d <= n; d++) if (n % d == 0) return 0;
        return 1;
    endfunction

    // Odd beat: no-op, out-of-range test or a sieve with a wide random value
    task automatic push_noise();
        longint unsigned used;
        used = sb.eff_len();
        case ($urandom_range(0, 2))
            0: push_item(slw_pkg::MODE_NOP, PW'($urandom), OW'($urandom));
            1: begin
                if (used < 65536)
                    push_item(slw_pkg::MODE_TEST, PW'($urandom),
                              OW'($urandom_range(32'(used), 65535)));
                else push_item(slw_pkg::MODE_NOP, PW'($urandom), OW'($urandom));
            end
            default: push_item(slw_pkg::MODE_SIEVE,
                               PW'($urandom_range(1 << 20, 24'hFF_FFFF)), OW'($urandom));
        endcase
    endtask

    // One setting: optional clear, ascending base-prime sieves, then candidate tests
    task automatic run_phase(bit [BW-1:0] base, bit [LW-1:0] len,
                             int pmin, int pmax, int n_items, bit wipe);
        int start;
        start = items_sent;
        drain();
        write_reg(slw_pkg::CFG_SEG_BASE, base);
        write_reg(slw_pkg::CFG_SEG_LEN, BW'(len));
        settings_used++;
        if (wipe) push_item(slw_pkg::MODE_CLEAR, PW'($urandom), OW'($urandom));
        for (int p = pmin; p <= pmax; p++) begin
            if (is_prime_int(p)) push_item(slw_pkg::MODE_SIEVE, PW'(p), OW'($urandom));
            if ($urandom_range(0, 99) < 10) push_noise();
        end
        while (items_sent - start < n_items) begin
            if ($urandom_range(0, 99) < 15) push_noise();
            else push_item(slw_pkg::MODE_TEST, PW'($urandom),
                           OW'($urandom_range(0, 32'(sb.eff_len() - 1))));
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = slw_pkg::CFG_SEG_BASE;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_mode        = slw_pkg::MODE_NOP;
        s_sieve_prime = '0;
        s_offset      = '0;
        calm          = 0;
        idle_cycles   = 0;
        items_sent    = 0;
        settings_used = 0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: small segment at zero, corner primes and offsets
        write_reg(slw_pkg::CFG_SEG_BASE, '0);
        write_reg(slw_pkg::CFG_SEG_LEN, BW'(100));
        settings_used++;
        push_item(slw_pkg::MODE_NOP, 24'hFF_FFFF, 16'hFFFF);
        push_item(slw_pkg::MODE_CLEAR, '0, '0);
        push_item(slw_pkg::MODE_SIEVE, '0, '0);
        push_item(slw_pkg::MODE_SIEVE, PW'(1), '0);
        push_item(slw_pkg::MODE_SIEVE, 24'hFF_FFFF, 16'hFFFF);
        foreach (small_primes[i])
            push_item(slw_pkg::MODE_SIEVE, PW'(small_primes[i]), '0);
        foreach (probe_offs[i])
            push_item(slw_pkg::MODE_TEST, 24'hFF_FFFF, OW'(probe_offs[i]));

        // Random phases over several segment settings
        run_phase(BW'($urandom_range(1000, 1000000)), LW'($urandom_range(200, 2000)),
                  2, 100, 300, 1);
        run_phase(BW'(2), '0, 2, 50, 60, 1);
        run_phase(48'hFFFF_FFFF_FFFF - 48'd1999, 17'h1FFFF, 300, 700, 250, 1);
        calm = 1;
        run_phase({16'h0, 32'($urandom)}, LW'(65536), 300, 700, 250, 1);
        calm = 0;
        run_phase(48'hFFFF_FFFF_FFFF, LW'(2), 1, 0, 8, 0);
        run_phase(BW'($urandom_range(0, 1 << 20)), LW'(1000), 2, 200, 280, 1);

        drain();
        repeat (20) @(negedge aclk);
        $display("Sent %0d beats over %0d segment settings; %0d results checked.",
                 items_sent, settings_used, sb.n_checked);
        $display("Results flagged %0d primes, %0d of them bad.", sb.n_prime, sb.n_bad);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/slw_pkg.sv
src/slw_ram.sv
src/slw_ctrl.sv
src/slw_dp.sv
src/segmented_lpf_sieve_window_test.sv
src/slw_checker.sv
tb/tb_segmented_lpf_sieve_window_test.sv
